// File: hdl/ptl_pkg.sv
`timescale 1ns / 1ps
// Package for the pressure table linearizer: breakpoint table, field widths
// and arithmetic widths. No dependencies.
package ptl_pkg;

	localparam int unsigned TABLE_POINTS = 24;
	localparam int unsigned NUM_SEGS     = TABLE_POINTS - 1;

	// Field widths.
	localparam int unsigned XW = 16;  // raw gauge counts
	localparam int unsigned YW = 15;  // millitorr

	// Datapath widths, sized for this table: widest segment spans 336 counts,
	// tallest segment rises 10000 mtorr.
	localparam int unsigned OFFW = 9;            // offset into a segment
	localparam int unsigned DYW  = 14;           // segment rise
	localparam int unsigned PW   = OFFW + DYW;   // offset * rise
	localparam int unsigned RW   = PW + 1;       // reciprocal, scaled by 2**PW
	localparam int unsigned QDW  = PW + OFFW;    // quotient estimate * run

	localparam logic [XW-1:0] BP_X [0:TABLE_POINTS-1] = '{
		16'd169,  16'd266,  16'd481,  16'd654,  16'd878,  16'd1048,
		16'd1176, 16'd1281, 16'd1367, 16'd1446, 16'd1512, 16'd1568,
		16'd1621, 16'd1957, 16'd2126, 16'd2233, 16'd2304, 16'd2356,
		16'd2395, 16'd2421, 16'd2440, 16'd2457, 16'd2545, 16'd2573
	};

	localparam logic [YW-1:0] BP_Y [0:TABLE_POINTS-1] = '{
		15'd0,     15'd10,    15'd50,    15'd100,   15'd200,   15'd300,
		15'd400,   15'd500,   15'd600,   15'd700,   15'd800,   15'd900,
		15'd1000,  15'd2000,  15'd3000,  15'd4000,  15'd5000,  15'd6000,
		15'd7000,  15'd8000,  15'd9000,  15'd10000, 15'd20000, 15'd20000
	};

endpackage

// File: hdl/pressure_table_linearizer_unit.sv
`timescale 1ns / 1ps
// Pressure table linearizer: raw gauge counts in, millitorr out, by
// piecewise linear interpolation. Depends on ptl_pkg.

// One reading enters per clock and its result leaves the unit by way of a
// six-stage registered pipeline: breakpoint compare, segment select,
// offset-times-rise multiply, reciprocal multiply, back-multiply, and a
// one-step quotient correction with the final add. A result is
// y0 + floor((x - x0) * (y1 - y0) / (x1 - x0)) over the first segment that
// holds the reading; a reading equal to a breakpoint gives that point's
// value. Readings below 169 counts return 0 and above 2573 counts return
// 20000, both with the out-of-table flag set in tuser. Each stage holds its
// own valid bit and moves when the stage after it is empty or moving, so a
// stall on the output side holds every transaction in place and bubbles
// close up; full throughput is one transaction per cycle when the
// downstream side keeps tready high. No state survives between readings.
module pressure_table_linearizer_unit
	import ptl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sensor_reading
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [14:0] pressure_millitorr, [15] zero
	output logic [0:0]  m_axis_tuser    // [0] out_of_table
);

	localparam int unsigned STAGES = 6;

	// Per-segment constants: run, rise and the reciprocal of the run,
	// ceil(2**PW / run). The estimate floor(p * recip / 2**PW) is then the
	// true quotient or one above it, for any p below 2**PW.
	logic [OFFW-1:0] seg_dx    [0:NUM_SEGS-1];
	logic [DYW-1:0]  seg_dy    [0:NUM_SEGS-1];
	logic [RW-1:0]   seg_recip [0:NUM_SEGS-1];

	for (genvar g = 0; g < NUM_SEGS; g++) begin : g_seg
		localparam int unsigned DX  = 32'(BP_X[g+1]) - 32'(BP_X[g]);
		localparam int unsigned DXS = (DX == 0) ? 1 : DX;
		localparam longint unsigned RC = ((64'd1 << PW) + 64'(DXS) - 64'd1) / 64'(DXS);
		assign seg_dx[g]    = OFFW'(DX);
		assign seg_dy[g]    = DYW'(BP_Y[g+1] - BP_Y[g]);
		assign seg_recip[g] = RW'(RC);
	end

	// Handshake: stage k loads when it is empty or its content moves on.
	logic [STAGES:1] vld;
	logic [STAGES+1:1] adv;

	always_comb begin
		adv[STAGES+1] = m_axis_tready;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign s_axis_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) begin
				vld[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// Stage 1: compare the reading against every breakpoint in parallel.
	logic [XW-1:0]       x_s1;
	logic [NUM_SEGS-1:0] hit_s1;
	logic                below_s1;
	logic                above_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_s1     <= s_axis_tdata;
			below_s1 <= s_axis_tdata < BP_X[0];
			above_s1 <= s_axis_tdata > BP_X[TABLE_POINTS-1];
			for (int i = 0; i < NUM_SEGS; i++) begin
				hit_s1[i] <= (s_axis_tdata >= BP_X[i]) && (s_axis_tdata <= BP_X[i+1]);
			end
		end
	end

	// Stage 2: pick the lowest segment that holds the reading. A clamped
	// reading gets a zero offset, so the arithmetic passes y0 straight through.
	logic [OFFW-1:0] sel_off;
	logic [DYW-1:0]  sel_dy;
	logic [OFFW-1:0] sel_dx;
	logic [RW-1:0]   sel_recip;
	logic [YW-1:0]   sel_y0;

	always_comb begin
		sel_off   = '0;
		sel_dy    = '0;
		sel_dx    = seg_dx[NUM_SEGS-1];
		sel_recip = seg_recip[NUM_SEGS-1];
		sel_y0    = BP_Y[TABLE_POINTS-1];
		if (below_s1) begin
			sel_y0 = BP_Y[0];
		end else if (!above_s1) begin
			// Scan downward so the lowest matching segment wins.
			for (int i = NUM_SEGS - 1; i >= 0; i--) begin
				if (hit_s1[i]) begin
					sel_off   = OFFW'(x_s1 - BP_X[i]);
					sel_dy    = seg_dy[i];
					sel_dx    = seg_dx[i];
					sel_recip = seg_recip[i];
					sel_y0    = BP_Y[i];
				end
			end
		end
	end

	logic [OFFW-1:0] off_s2;
	logic [DYW-1:0]  dy_s2;
	logic [OFFW-1:0] dx_s2;
	logic [RW-1:0]   recip_s2;
	logic [YW-1:0]   y0_s2;
	logic            clamp_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			off_s2   <= sel_off;
			dy_s2    <= sel_dy;
			dx_s2    <= sel_dx;
			recip_s2 <= sel_recip;
			y0_s2    <= sel_y0;
			clamp_s2 <= below_s1 || above_s1;
		end
	end

	// Stage 3: offset times rise.
	logic [PW-1:0]   p_s3;
	logic [OFFW-1:0] dx_s3;
	logic [RW-1:0]   recip_s3;
	logic [YW-1:0]   y0_s3;
	logic            clamp_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			p_s3     <= PW'(off_s2) * PW'(dy_s2);
			dx_s3    <= dx_s2;
			recip_s3 <= recip_s2;
			y0_s3    <= y0_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// Stage 4: quotient estimate through the reciprocal.
	logic [PW+RW-1:0] pm;
	logic [PW-1:0]    qe_s4;
	logic [PW-1:0]    p_s4;
	logic [OFFW-1:0]  dx_s4;
	logic [YW-1:0]    y0_s4;
	logic             clamp_s4;

	assign pm = (PW+RW)'(p_s3) * (PW+RW)'(recip_s3);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			qe_s4    <= pm[PW +: PW];
			p_s4     <= p_s3;
			dx_s4    <= dx_s3;
			y0_s4    <= y0_s3;
			clamp_s4 <= clamp_s3;
		end
	end

	// Stage 5: multiply the estimate back by the run.
	logic [QDW-1:0] qd_s5;
	logic [PW-1:0]  qe_s5;
	logic [PW-1:0]  p_s5;
	logic [YW-1:0]  y0_s5;
	logic           clamp_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			qd_s5    <= QDW'(qe_s4) * QDW'(dx_s4);
			qe_s5    <= qe_s4;
			p_s5     <= p_s4;
			y0_s5    <= y0_s4;
			clamp_s5 <= clamp_s4;
		end
	end

	// Stage 6: drop the estimate by one where it overshoots, then add y0.
	logic [PW-1:0] q_fix;

	assign q_fix = (qd_s5 > QDW'(p_s5)) ? (qe_s5 - PW'(1)) : qe_s5;

	logic [YW-1:0] y_s6;
	logic          clamp_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			y_s6     <= y0_s5 + q_fix[YW-1:0];
			clamp_s6 <= clamp_s5;
		end
	end

	assign m_axis_tvalid = vld[STAGES];
	assign m_axis_tdata  = {1'b0, y_s6};
	assign m_axis_tuser  = clamp_s6;

endmodule

// File: sim/pressure_table_linearizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pressure_table_linearizer_unit: drives raw gauge
// readings, predicts millitorr and the clamp flag, and checks every output
// transaction in order. Depends on ptl_pkg and the unit under test.
module pressure_table_linearizer_unit_tb;
	import ptl_pkg::*;

	localparam int unsigned RESET_CYCLES     = 8;
	localparam int unsigned WATCHDOG_LIMIT   = 4000;
	localparam int unsigned SINK_HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_TAIL       = 24;
	localparam int unsigned MAX_REPORTS      = 10;
	localparam int unsigned GAUGE_POINTS     = 24;

	// Gauge calibration: counts against millitorr.
	localparam int unsigned GAUGE_X [0:GAUGE_POINTS-1] = '{
		169, 266, 481, 654, 878, 1048, 1176, 1281, 1367, 1446, 1512, 1568,
		1621, 1957, 2126, 2233, 2304, 2356, 2395, 2421, 2440, 2457, 2545, 2573
	};
	localparam int unsigned GAUGE_Y [0:GAUGE_POINTS-1] = '{
		0, 10, 50, 100, 200, 300, 400, 500, 600, 700, 800, 900,
		1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000, 20000, 20000
	};

	typedef struct packed {
		logic [XW-1:0] reading;
		logic [YW-1:0] mtorr;
		logic          clamped;
	} gauge_result_t;

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [15:0]   s_axis_tdata  = 16'd0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [15:0]   m_axis_tdata;
	logic [0:0]    m_axis_tuser;

	gauge_result_t pending_pressures [$];

	// Shared between the test tasks, the sink, the checker and the watchdog.
	bit          idle_on       = 1'b0;
	bit          sink_hold_req = 1'b0;
	int unsigned fail_count    = 0;
	int unsigned checked_count = 0;
	int unsigned sent_count    = 0;
	int unsigned low_count     = 0;
	int unsigned high_count    = 0;
	int unsigned bp_count      = 0;
	int unsigned idle_cycles   = 0;

	pressure_table_linearizer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Interpolate over the first segment that holds the reading; clamp outside.
	function automatic gauge_result_t predict_pressure(input logic [XW-1:0] reading);
		gauge_result_t res;
		int unsigned   x;
		int unsigned   y;
		bit            found;
		x           = 32'(reading);
		y           = GAUGE_Y[GAUGE_POINTS-1];
		found       = 1'b0;
		res.reading = reading;
		res.clamped = 1'b0;
		if (x > GAUGE_X[GAUGE_POINTS-1]) begin
			res.clamped = 1'b1;
		end else if (x < GAUGE_X[0]) begin
			y           = GAUGE_Y[0];
			res.clamped = 1'b1;
		end else begin
			for (int i = 0; i < GAUGE_POINTS - 1; i++) begin
				if (!found && x >= GAUGE_X[i] && x <= GAUGE_X[i+1]) begin
					found = 1'b1;
					if (x == GAUGE_X[i])
						y = GAUGE_Y[i];
					else if (x == GAUGE_X[i+1])
						y = GAUGE_Y[i+1];
					else
						y = GAUGE_Y[i] + ((x - GAUGE_X[i]) * (GAUGE_Y[i+1] - GAUGE_Y[i]))
							/ (GAUGE_X[i+1] - GAUGE_X[i]);
				end
			end
		end
		res.mtorr = y[YW-1:0];
		return res;
	endfunction

	function automatic bit on_breakpoint(input logic [XW-1:0] reading);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < GAUGE_POINTS; i++)
			if (32'(reading) == GAUGE_X[i])
				hit = 1'b1;
		return hit;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Bias toward the table interior and the breakpoints, keep some noise.
	function automatic logic [XW-1:0] pick_reading();
		int unsigned r;
		int unsigned idx;
		r = $urandom_range(0, 99);
		if (r < 55)
			return XW'($urandom_range(GAUGE_X[0], GAUGE_X[GAUGE_POINTS-1]));
		if (r < 75) begin
			idx = $urandom_range(0, GAUGE_POINTS - 1);
			return XW'(GAUGE_X[idx] + $urandom_range(0, 2) - 1);
		end
		if (r < 85)
			return XW'($urandom_range(0, GAUGE_X[0] - 1));
		if (r < 95)
			return XW'($urandom_range(GAUGE_X[GAUGE_POINTS-1] + 1, 65535));
		return XW'($urandom);
	endfunction

	// Offer one reading after an optional gap, hold it until accepted.
	task automatic push_reading(input logic [XW-1:0] reading, input int unsigned gap);
		gauge_result_t want;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 16'($urandom);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= reading;
		do
			@(posedge clk);
		while (!s_axis_tready);
		want = predict_pressure(reading);
		pending_pressures.push_back(want);
		sent_count++;
		if (want.clamped && want.mtorr == 0)
			low_count++;
		else if (want.clamped)
			high_count++;
		if (on_breakpoint(reading))
			bp_count++;
	endtask

	function automatic int unsigned sender_gap();
		if (idle_on && $urandom_range(0, 99) < 25)
			return pick_gap();
		return 0;
	endfunction

	task automatic test_clamp_edges();
		logic [XW-1:0] edge_readings [0:9];
		edge_readings = '{16'd0, 16'd1, 16'd168, 16'd169, 16'd170,
			16'd2572, 16'd2573, 16'd2574, 16'hFFFF, 16'h8000};
		idle_on = 1'b1;
		foreach (edge_readings[i])
			push_reading(edge_readings[i], sender_gap());
	endtask

	task automatic test_breakpoint_hits();
		logic [XW-1:0] bp_readings [0:11];
		// Shared breakpoints, the steep and the flat segment, bit patterns.
		bp_readings = '{16'd266, 16'd481, 16'd1621, 16'd1957, 16'd2456, 16'd2457,
			16'd2458, 16'd2501, 16'd2545, 16'd2560, 16'h5555, 16'hAAAA};
		idle_on = 1'b1;
		foreach (bp_readings[i])
			push_reading(bp_readings[i], sender_gap());
	endtask

	// Long random run; every 250 transactions drop idling for a stretch.
	task automatic test_random_readings(input int unsigned count);
		for (int unsigned k = 0; k < count; k++) begin
			idle_on = ((k % 250) < 200);
			push_reading(pick_reading(), sender_gap());
		end
	endtask

	// Hold the sink off long enough to fill the pipeline and stall the input.
	task automatic test_output_backpressure(input int unsigned count);
		idle_on       = 1'b0;
		sink_hold_req = 1'b1;
		for (int unsigned k = 0; k < count; k++)
			push_reading(pick_reading(), 0);
	endtask

	task automatic test_back_to_back(input int unsigned count);
		idle_on = 1'b0;
		for (int unsigned k = 0; k < count; k++)
			push_reading(pick_reading(), 0);
	endtask

	// Sink: random stalls while idling is on, plus the requested long hold-off.
	initial begin : sink_proc
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				stall_left    = SINK_HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// Compare each output transaction with the oldest pending prediction.
	always @(posedge clk) begin
		gauge_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pressures.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t: unexpected result %0d flag %0b", $realtime,
						m_axis_tdata[YW-1:0], m_axis_tuser[0]);
				fail_count++;
			end else begin
				want = pending_pressures.pop_front();
				checked_count++;
				if (m_axis_tdata[YW-1:0] !== want.mtorr || m_axis_tdata[15] !== 1'b0
						|| m_axis_tuser[0] !== want.clamped) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: reading %0d expected %0d flag %0b, got %0d flag %0b pad %b",
							$realtime, want.reading, want.mtorr, want.clamped,
							m_axis_tdata[YW-1:0], m_axis_tuser[0], m_axis_tdata[15]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d pending",
					idle_cycles, pending_pressures.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_clamp_edges();
		test_breakpoint_hits();
		test_random_readings(1000);
		test_output_backpressure(60);
		test_back_to_back(140);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_pressures.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Sent %0d readings (%0d clamped low, %0d clamped high, %0d on breakpoints)",
			sent_count, low_count, high_count, bp_count);
		$display("Checked %0d results with random stalls and a %0d-cycle sink hold-off",
			checked_count, SINK_HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/ptl_pkg.sv
hdl/pressure_table_linearizer_unit.sv
sim/pressure_table_linearizer_unit_tb.sv
